FILE: sv/bf7_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf7_pkg
// Shared types and constants of the box mean filter: field widths, register
// and action codes, and the stage word passed from the counters to the window.
// ----------------------------------------------------------------------------
package bf7_pkg;

  localparam int PIXEL_W  = 8;
  localparam int ROW_W    = 12;
  localparam int COL_OUT_W = 10;
  localparam int WIDTH_CFG_W  = 11;
  localparam int HEIGHT_CFG_W = 13;

  localparam int MIN_SIZE     = 7;
  localparam int MAX_HEIGHT   = 4096;
  localparam int RESET_WIDTH  = 256;
  localparam int RESET_HEIGHT = 256;

  // Register indexes, decoded from paddr[2].
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // Input actions.
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef logic [PIXEL_W-1:0]   pixel_t;
  typedef logic [ROW_W-1:0]     row_t;
  typedef logic [COL_OUT_W-1:0] col_out_t;

  localparam pixel_t BLACK = '0;

  // One accepted word on its way through the window pipeline.
  typedef struct packed {
    logic     take;      // pixel enters the line store and the window
    logic     emit;      // word gives a result
    pixel_t   px;
    logic     interior;  // result position is away from every edge
    logic     last;
    row_t     row;
    col_out_t col;
  } bf7_item_t;

endpackage

FILE: sv/bf7_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf7_in_if
// Input channel: one pixel or flush word per handshake.
// ----------------------------------------------------------------------------
interface bf7_in_if import bf7_pkg::*;;
  logic   valid;
  logic   ready;
  logic   action;
  pixel_t pixel;

  modport source (output valid, output action, output pixel, input ready);
  modport sink   (input valid, input action, input pixel, output ready);
endinterface

FILE: sv/bf7_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf7_out_if
// Output channel: one filtered pixel with its position per handshake.
// ----------------------------------------------------------------------------
interface bf7_out_if import bf7_pkg::*;;
  logic     valid;
  logic     ready;
  pixel_t   value;
  row_t     row;
  col_out_t col;
  logic     last;

  modport source (output valid, output value, output row, output col, output last,
                  input ready);
  modport sink   (input valid, input value, input row, input col, input last,
                  output ready);
endinterface

FILE: sv/bf7_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf7_regs
// APB register file holding the image width and height, clamped on write.
// ----------------------------------------------------------------------------
module bf7_regs import bf7_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [$clog2(MAX_WIDTH+1)-1:0] image_width,
  output logic [HEIGHT_CFG_W-1:0]        image_height
);

  localparam int WREG_W = $clog2(MAX_WIDTH+1);
  localparam int RST_W  = (RESET_WIDTH < MAX_WIDTH) ? RESET_WIDTH : MAX_WIDTH;

  logic                    wr;
  logic [WIDTH_CFG_W-1:0]  w_raw;
  logic [HEIGHT_CFG_W-1:0] h_raw;
  logic [WREG_W-1:0]       w_clamped;
  logic [HEIGHT_CFG_W-1:0] h_clamped;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // Clamp the written values into the supported range.
  always_comb begin
    w_raw = pwdata[WIDTH_CFG_W-1:0];
    h_raw = pwdata[HEIGHT_CFG_W-1:0];
    if (32'(w_raw) < 32'(MIN_SIZE)) begin
      w_clamped = WREG_W'(MIN_SIZE);
    end else if (32'(w_raw) > 32'(MAX_WIDTH)) begin
      w_clamped = WREG_W'(MAX_WIDTH);
    end else begin
      w_clamped = WREG_W'(w_raw);
    end
    if (32'(h_raw) < 32'(MIN_SIZE)) begin
      h_clamped = HEIGHT_CFG_W'(MIN_SIZE);
    end else if (32'(h_raw) > 32'(MAX_HEIGHT)) begin
      h_clamped = HEIGHT_CFG_W'(MAX_HEIGHT);
    end else begin
      h_clamped = h_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WREG_W'(RST_W);
      image_height <= HEIGHT_CFG_W'(RESET_HEIGHT);
    end else if (wr) begin
      unique case (paddr[2])
        REG_IMAGE_WIDTH:  image_width  <= w_clamped;
        REG_IMAGE_HEIGHT: image_height <= h_clamped;
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (paddr[2])
      REG_IMAGE_WIDTH:  prdata = 32'(image_width);
      REG_IMAGE_HEIGHT: prdata = 32'(image_height);
      default:          prdata = '0;
    endcase
  end

endmodule

FILE: sv/bf7_line_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf7_line_store
// One-port-read, one-port-write RAM holding the previous rows of each column,
// with a registered read.
// ----------------------------------------------------------------------------
module bf7_line_store #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 48
) (
  input  logic                     clk,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/bf7_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf7_window
// Window pipeline: writes the shifted column back to the line store, keeps
// the column sums of the window, adds them and divides by the tap count.
// ----------------------------------------------------------------------------
module bf7_window import bf7_pkg::*; #(
  parameter int WINDOW    = 7,
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  bf7_item_t                     item,
  input  logic [$clog2(MAX_WIDTH)-1:0]  addr,
  output logic                          ready,
  input  logic [(WINDOW-1)*PIXEL_W-1:0] mem_rdata,
  output logic                          mem_we,
  output logic [$clog2(MAX_WIDTH)-1:0]  mem_waddr,
  output logic [(WINDOW-1)*PIXEL_W-1:0] mem_wdata,
  bf7_out_if.source                     out_ch
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int DW    = (WINDOW-1)*PIXEL_W;
  localparam int TAPS  = WINDOW*WINDOW;
  localparam int CS_W  = $clog2(WINDOW*255+1);
  localparam int WS_W  = $clog2(TAPS*255+1);
  // floor(s / TAPS) = (s * RECIP) >> SHIFT for every sum below 2^16.
  localparam int SHIFT = 24;
  localparam int RECIP = ((1 << SHIFT) + TAPS - 1) / TAPS;
  localparam int RC_W  = $clog2(RECIP+1);
  localparam int PW    = WS_W + RC_W;

  logic            s1_valid;
  bf7_item_t       s1_item;
  logic [AW-1:0]   s1_addr;
  logic            s2_valid;
  bf7_item_t       s2_item;
  logic            s3_valid;
  bf7_item_t       s3_item;
  logic [WS_W-1:0] s3_sum;
  logic            out_valid;

  logic [CS_W-1:0] colsum [WINDOW];
  logic [CS_W-1:0] col_new;
  logic [WS_W-1:0] win_sum;
  logic [PW-1:0]   prod;
  pixel_t          quot;

  logic ov_free, m1, m2, m3, f2, f3;

  // Elastic stage control: a stage moves on when the next one is empty or moving.
  always_comb begin
    ov_free = !out_valid || out_ch.ready;
    m3      = s3_valid && ov_free;
    f3      = !s3_valid || m3;
    m2      = s2_valid && f3;
    f2      = !s2_valid || m2;
    m1      = s1_valid && f2;
    ready   = !s1_valid || m1;
  end

  // Sum of the new column: the stored rows of this column plus the new pixel.
  always_comb begin
    col_new = CS_W'(s1_item.px);
    for (int k = 0; k < WINDOW-1; k++) begin
      col_new = col_new + CS_W'(mem_rdata[k*PIXEL_W +: PIXEL_W]);
    end
  end

  // Window sum over the column sums.
  always_comb begin
    win_sum = '0;
    for (int k = 0; k < WINDOW; k++) begin
      win_sum = win_sum + WS_W'(colsum[k]);
    end
  end

  // Division by the tap count as a reciprocal multiply.
  always_comb begin
    prod = PW'(s3_sum) * PW'(RECIP);
    quot = PIXEL_W'(prod >> SHIFT);
  end

  // Write-back of the column, shifted down by one row.
  assign mem_we    = m1 && s1_item.take;
  assign mem_waddr = s1_addr;
  assign mem_wdata = {mem_rdata[DW-PIXEL_W-1:0], s1_item.px};

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k < WINDOW; k++) begin
        colsum[k] <= '0;
      end
    end else begin
      if (ready) begin
        s1_valid <= load;
      end
      if (f2) begin
        s2_valid <= m1 && s1_item.emit;
      end
      if (f3) begin
        s3_valid <= m2;
      end
      if (ov_free) begin
        out_valid <= m3;
      end
      if (m1 && s1_item.take) begin
        for (int k = 0; k < WINDOW-1; k++) begin
          colsum[k] <= colsum[k+1];
        end
        colsum[WINDOW-1] <= col_new;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ready) begin
      s1_item <= item;
      s1_addr <= addr;
    end
    if (f2) begin
      s2_item <= s1_item;
    end
    if (f3) begin
      s3_item <= s2_item;
      s3_sum  <= win_sum;
    end
    if (ov_free) begin
      out_ch.value <= s3_item.interior ? quot : BLACK;
      out_ch.row   <= s3_item.row;
      out_ch.col   <= s3_item.col;
      out_ch.last  <= s3_item.last;
    end
  end

  assign out_ch.valid = out_valid;

endmodule

FILE: sv/box_filter_7x7_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_filter_7x7_unit
// Streaming WINDOW x WINDOW box mean filter over 8-bit grey pixels.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order on in_ch (action 0 carries a pixel). Each
// image position gives one word on out_ch: the floor of its neighborhood sum
// divided by WINDOW*WINDOW, or black within WINDOW/2 of any edge, with its
// row, column and a last flag on the final position of the frame.
// Results trail the input by WINDOW/2 rows plus WINDOW/2 pixels; after the
// last pixel of a frame the host sends flush words (action 1), one result per
// word, until last. Flush words before the last pixel give nothing.
// Throughput is one word per cycle while out_ch does not stall; the line
// store is read at accept and written back as the word leaves stage s1.
// A word that gives a result passes s1, s2, s3 and the output register.
// When out_ch stalls, the four pipeline stages fill and in_ch.ready drops
// only once every stage holds a word. Reset clears the counters, pipeline
// and window sums and sets width and height to 256; the line store is not
// cleared. The APB port holds image_width at 0x0 and image_height at 0x4.
// ----------------------------------------------------------------------------
module box_filter_7x7_unit import bf7_pkg::*; #(
  parameter int WINDOW    = 7,
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  bf7_in_if.sink      in_ch,
  bf7_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int WREG_W = $clog2(MAX_WIDTH+1);
  localparam int DW     = (WINDOW-1)*PIXEL_W;
  localparam int HALF   = WINDOW/2;

  logic [WREG_W-1:0]       image_width;
  logic [HEIGHT_CFG_W-1:0] image_height;

  logic [ROW_W-1:0] in_row, out_row;
  logic [AW-1:0]    in_col, out_col;
  logic             in_done;

  logic      accept, take, emit, lead_met, interior, fin, pipe_ready;
  bf7_item_t item;

  logic [DW-1:0] mem_rdata, mem_wdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;

  bf7_regs #(.MAX_WIDTH(MAX_WIDTH)) u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .image_width  (image_width),
    .image_height (image_height)
  );

  // Step decode from the frame counters.
  always_comb begin
    accept   = in_ch.valid && in_ch.ready;
    lead_met = (32'(in_row) > 32'(HALF)) ||
               ((32'(in_row) == 32'(HALF)) && (32'(in_col) >= 32'(HALF)));
    take     = accept && !in_done && (in_ch.action == ACT_PIXEL);
    emit     = accept && (in_done || ((in_ch.action == ACT_PIXEL) && lead_met));
    interior = (32'(out_row) >= 32'(HALF)) &&
               (32'(out_row) + 32'(HALF) < 32'(image_height)) &&
               (32'(out_col) >= 32'(HALF)) &&
               (32'(out_col) + 32'(HALF) < 32'(image_width));
    fin      = (32'(out_row) + 32'd1 >= 32'(image_height)) &&
               (32'(out_col) + 32'd1 >= 32'(image_width));
    item.take     = take;
    item.emit     = emit;
    item.px       = in_ch.pixel;
    item.interior = interior;
    item.last     = fin;
    item.row      = out_row;
    item.col      = COL_OUT_W'(out_col);
  end

  assign in_ch.ready = pipe_ready;

  // Input and output position counters; the last result restarts the frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
      in_done <= 1'b0;
    end else begin
      if (take) begin
        if (32'(in_col) + 32'd1 >= 32'(image_width)) begin
          in_col <= '0;
          if (32'(in_row) + 32'd1 >= 32'(image_height)) begin
            in_done <= 1'b1;
          end else begin
            in_row <= in_row + 1'b1;
          end
        end else begin
          in_col <= in_col + 1'b1;
        end
      end
      if (emit) begin
        if (fin) begin
          in_row  <= '0;
          in_col  <= '0;
          out_row <= '0;
          out_col <= '0;
          in_done <= 1'b0;
        end else if (32'(out_col) + 32'd1 >= 32'(image_width)) begin
          out_col <= '0;
          out_row <= out_row + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
    end
  end

  bf7_line_store #(.DEPTH(MAX_WIDTH), .DATA_W(DW)) u_line_store (
    .clk   (clk),
    .re    (take),
    .raddr (in_col),
    .rdata (mem_rdata),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata)
  );

  bf7_window #(.WINDOW(WINDOW), .MAX_WIDTH(MAX_WIDTH)) u_window (
    .clk       (clk),
    .rst       (rst),
    .load      (take || emit),
    .item      (item),
    .addr      (in_col),
    .ready     (pipe_ready),
    .mem_rdata (mem_rdata),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .out_ch    (out_ch)
  );

endmodule
